// ----- hdl/ssplit_pkg.sv -----
// ssplit_pkg: shared types and constants of the delimiter string splitter
// no dependencies; used by the interfaces, the window row, the output buffer and the top level

package ssplit_pkg;

  // configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 64;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_DELIM_CHARS = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DELIM_LEN   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SKIP_EMPTY  = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PIECE_LIMIT = 2'd3;

  // register and field widths
  localparam int DELIM_CHARS_BITS = 64;
  localparam int DLEN_BITS        = 4;
  localparam int COUNT_BITS       = 16;
  localparam int OUT_CHAR_BITS    = 8;

  // reset values
  localparam logic [DLEN_BITS-1:0]  DLEN_RESET      = 4'd1;
  localparam logic [COUNT_BITS-1:0] LIMIT_UNLIMITED = 16'hFFFF;

  // per-step command to the window row
  typedef struct packed {
    logic step;    // window takes its next value this cycle
    logic append;  // new character enters at position fill
    logic shift;   // oldest character leaves toward the output
  } win_op_t;

  // one result beat
  typedef struct packed {
    logic [OUT_CHAR_BITS-1:0] out_char;
    logic                     out_char_valid;
    logic                     piece_end;
    logic                     string_done;
  } res_t;

endpackage

// ----- hdl/ssplit_if.sv -----
// ssplit_in_if and ssplit_out_if: valid/ready channels of the splitter
// depends on ssplit_pkg for the result character width

interface ssplit_in_if #(
  parameter int CHAR_BITS = 8
);
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] in_char;
  logic                 char_present;
  logic                 string_last;

  modport source (output valid, output in_char, output char_present, output string_last,
                  input ready);
  modport sink   (input valid, input in_char, input char_present, input string_last,
                  output ready);
endinterface

interface ssplit_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [ssplit_pkg::OUT_CHAR_BITS-1:0] out_char;
  logic                                 out_char_valid;
  logic                                 piece_end;
  logic                                 string_done;

  modport source (output valid, output out_char, output out_char_valid, output piece_end,
                  output string_done, input ready);
  modport sink   (input valid, input out_char, input out_char_valid, input piece_end,
                  input string_done, output ready);
endinterface

// ----- hdl/ssplit_cell.sv -----
// ssplit_cell: one position of the look-ahead window with its delimiter compare
// depends on ssplit_pkg (win_op_t)

module ssplit_cell #(
  parameter int IDX       = 0,
  parameter int DELIM_MAX = 8,
  parameter int CHAR_BITS = 8
) (
  input  logic                                  clk,
  input  ssplit_pkg::win_op_t                   op,
  input  logic [$clog2(DELIM_MAX+1)-1:0]        fill,
  input  logic [$clog2(DELIM_MAX+1)-1:0]        len,
  input  logic [CHAR_BITS-1:0]                  new_char,
  input  logic [CHAR_BITS-1:0]                  right_char,
  input  logic [CHAR_BITS-1:0]                  delim_char,
  input  logic                                  ok_in,
  output logic [CHAR_BITS-1:0]                  vchar,
  output logic                                  ok_out
);

  localparam int FW = $clog2(DELIM_MAX + 1);

  logic [CHAR_BITS-1:0] q;

  // content as seen this cycle, with the arriving character written in
  assign vchar = (op.append && (fill == FW'(IDX))) ? new_char : q;

  // match chain: positions past the delimiter length always agree
  assign ok_out = ok_in && ((FW'(IDX) >= len) || (vchar == delim_char));

  // take the neighbor's character on a shift, else keep own
  always_ff @(posedge clk) begin
    if (op.step) begin
      q <= op.shift ? right_char : vchar;
    end
  end

endmodule

// ----- hdl/ssplit_window.sv -----
// ssplit_window: row of window cells, head character and delimiter match
// depends on ssplit_pkg and ssplit_cell

module ssplit_window #(
  parameter int DELIM_MAX = 8,
  parameter int CHAR_BITS = 8
) (
  input  logic                                    clk,
  input  ssplit_pkg::win_op_t                     op,
  input  logic [$clog2(DELIM_MAX+1)-1:0]          fill,
  input  logic [$clog2(DELIM_MAX+1)-1:0]          len,
  input  logic [CHAR_BITS-1:0]                    new_char,
  input  logic [ssplit_pkg::DELIM_CHARS_BITS-1:0] delim_chars,
  output logic [CHAR_BITS-1:0]                    head,
  output logic                                    match
);

  logic [CHAR_BITS-1:0] v  [0:DELIM_MAX];
  logic                 ok [0:DELIM_MAX];

  // ends of the chains
  assign v[DELIM_MAX] = '0;
  assign ok[0]        = 1'b1;

  for (genvar i = 0; i < DELIM_MAX; i++) begin : g_cell
    logic [CHAR_BITS-1:0] dch;

    // delimiter character for this position, zero past the register
    if (i * CHAR_BITS >= ssplit_pkg::DELIM_CHARS_BITS) begin : g_zero
      assign dch = '0;
    end else begin : g_take
      logic [ssplit_pkg::DELIM_CHARS_BITS-1:0] sh;
      assign sh  = delim_chars >> (i * CHAR_BITS);
      assign dch = sh[CHAR_BITS-1:0];
    end

    ssplit_cell #(
      .IDX       (i),
      .DELIM_MAX (DELIM_MAX),
      .CHAR_BITS (CHAR_BITS)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .fill       (fill),
      .len        (len),
      .new_char   (new_char),
      .right_char (v[i+1]),
      .delim_char (dch),
      .ok_in      (ok[i]),
      .vchar      (v[i]),
      .ok_out     (ok[i+1])
    );
  end

  assign head  = v[0];
  assign match = ok[DELIM_MAX];

endmodule

// ----- hdl/ssplit_obuf.sv -----
// ssplit_obuf: two-entry result buffer driving the output channel
// depends on ssplit_pkg (res_t) and ssplit_out_if

module ssplit_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ssplit_pkg::res_t  din,
  output logic              space,
  ssplit_out_if.source      res
);

  ssplit_pkg::res_t mem [0:1];
  logic             wp;
  logic             rp;
  logic [1:0]       cnt;
  logic             pop;

  assign pop = res.valid && res.ready;

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  assign space              = (cnt != 2'd2);
  assign res.valid          = (cnt != 2'd0);
  assign res.out_char       = mem[rp].out_char;
  assign res.out_char_valid = mem[rp].out_char_valid;
  assign res.piece_end      = mem[rp].piece_end;
  assign res.string_done    = mem[rp].string_done;

endmodule

// ----- hdl/delimiter_string_splitter.sv -----
// delimiter_string_splitter: top level, item register, step control and configuration
// depends on ssplit_pkg, ssplit_if, ssplit_window and ssplit_obuf
//
// Usage: strings enter on in_ch one character per beat; string_last marks the
// final beat, and a beat with char_present low only ends the string. Results
// leave on out_ch: piece characters (out_char_valid), piece ends (piece_end),
// and string_done on the last result of each string. Registers are written on
// cfg_we with cfg_index/cfg_data; the user must write them only while no
// string is in flight; the block does not enforce this. Throughput: one input
// beat per cycle while each beat gives at most one result and the result buffer
// has space; a beat with more results holds in_ch, as the window row steps once
// per result. A flush at string end shifts out the held characters, then the
// piece end; a match at string end with empty pieces kept gives its piece end,
// then an empty one with string_done unless the piece limit is reached.
// Reset: synchronous, clears the registers to their defaults and empties the
// window, item register and result buffer.
// Stall: a two-entry result buffer decouples out_ch; while it is full the
// control holds its step, and in_ch drops ready once the item register is held.

module delimiter_string_splitter #(
  parameter int DELIM_MAX = 8,
  parameter int CHAR_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  ssplit_in_if.sink                             in_ch,
  ssplit_out_if.source                          out_ch,
  input  logic                                  cfg_we,
  input  logic [ssplit_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ssplit_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int FW = $clog2(DELIM_MAX + 1);
  localparam int CB = ssplit_pkg::COUNT_BITS;

  // configuration registers
  logic [ssplit_pkg::DELIM_CHARS_BITS-1:0] delim_chars;
  logic [ssplit_pkg::DLEN_BITS-1:0]        delim_len;
  logic                                    skip_empty;
  logic [CB-1:0]                           piece_limit;

  // item register
  logic                 cur_v;
  logic [CHAR_BITS-1:0] cur_char;
  logic                 cur_last;
  logic                 cp;   // character work still open
  logic                 ap;   // character not yet in the window
  logic                 any;  // item already gave a result

  // string state
  logic [FW-1:0] fill;
  logic          pne;
  logic [CB-1:0] pieces;
  logic          lim_r;

  // step logic
  logic                 space;
  logic                 fire;
  logic                 finish;
  logic                 load;
  logic [FW-1:0]        len_eff;
  logic                 stop_now;
  logic                 stop_after;
  logic [CB-1:0]        pinc;
  logic                 app_now;
  logic [CHAR_BITS-1:0] head;
  logic                 match;
  logic                 fall;
  logic                 run;
  logic [FW-1:0]        fv;
  logic                 end_str;
  logic                 emit;
  ssplit_pkg::res_t     res;
  ssplit_pkg::win_op_t  op;
  logic [FW-1:0]        fill_next;
  logic                 pne_next;
  logic [CB-1:0]        pieces_next;
  logic                 lim_next;
  logic                 cp_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      delim_chars <= '0;
      delim_len   <= ssplit_pkg::DLEN_RESET;
      skip_empty  <= 1'b1;
      piece_limit <= ssplit_pkg::LIMIT_UNLIMITED;
    end else if (cfg_we) begin
      case (cfg_index)
        ssplit_pkg::REG_DELIM_CHARS: delim_chars <= cfg_data;
        ssplit_pkg::REG_DELIM_LEN:   delim_len   <= cfg_data[ssplit_pkg::DLEN_BITS-1:0];
        ssplit_pkg::REG_SKIP_EMPTY:  skip_empty  <= cfg_data[0];
        ssplit_pkg::REG_PIECE_LIMIT: piece_limit <= cfg_data[CB-1:0];
        default: ;
      endcase
    end
  end

  // delimiter length saturated to the window depth
  always_comb begin
    if (32'(delim_len) > 32'(DELIM_MAX)) begin
      len_eff = FW'(DELIM_MAX);
    end else begin
      len_eff = FW'(delim_len);
    end
  end

  // piece limit checks, before and after one more piece
  assign pinc       = (pieces == '1) ? pieces : pieces + CB'(1);
  assign stop_now   = lim_r ||
                      ((piece_limit != ssplit_pkg::LIMIT_UNLIMITED) && (pieces >= piece_limit));
  assign stop_after = lim_r ||
                      ((piece_limit != ssplit_pkg::LIMIT_UNLIMITED) && (pinc >= piece_limit));

  assign fire    = cur_v && space;
  assign app_now = cp && ap && !stop_now;
  assign fv      = fill + FW'(app_now);

  // one step: at most one result per cycle
  always_comb begin
    op.step     = fire;
    op.append   = app_now;
    op.shift    = 1'b0;
    emit        = 1'b0;
    res         = '0;
    finish      = 1'b0;
    end_str     = 1'b0;
    fall        = 1'b1;
    run         = 1'b0;
    fill_next   = (len_eff == '0) ? '0 : fill;
    pne_next    = pne;
    pieces_next = pieces;
    lim_next    = lim_r;
    cp_next     = cp;

    // character part
    if (cp) begin
      if (ap && stop_now) begin
        lim_next = 1'b1;
        cp_next  = 1'b0;
      end else if (fv > len_eff) begin
        emit               = 1'b1;
        res.out_char       = head[ssplit_pkg::OUT_CHAR_BITS-1:0];
        res.out_char_valid = 1'b1;
        op.shift           = 1'b1;
        fill_next          = fv - FW'(1);
        pne_next           = 1'b1;
        fall               = 1'b0;
      end else if (fv == len_eff) begin
        cp_next = 1'b0;
        if (match) begin
          fill_next = '0;
          pne_next  = 1'b0;
          if (pne || !skip_empty) begin
            emit          = 1'b1;
            res.piece_end = 1'b1;
            pieces_next   = pinc;
            fall          = 1'b0;
            if (!cur_last) begin
              finish = 1'b1;
            end else if (skip_empty || stop_after) begin
              res.string_done = 1'b1;
              end_str         = 1'b1;
              finish          = 1'b1;
            end
          end
        end else begin
          emit               = 1'b1;
          res.out_char       = head[ssplit_pkg::OUT_CHAR_BITS-1:0];
          res.out_char_valid = 1'b1;
          op.shift           = 1'b1;
          fill_next          = fv - FW'(1);
          pne_next           = 1'b1;
          fall               = 1'b0;
          finish             = !cur_last;
        end
      end else begin
        fill_next = fv;
        cp_next   = 1'b0;
      end
    end

    // end-of-string part, when the character part gave nothing
    if (fall) begin
      if (!cur_last) begin
        finish = 1'b1;
      end else begin
        run = (len_eff != '0) && !stop_now;
        if (run && (fill_next != '0)) begin
          emit               = 1'b1;
          res.out_char       = head[ssplit_pkg::OUT_CHAR_BITS-1:0];
          res.out_char_valid = 1'b1;
          op.shift           = 1'b1;
          fill_next          = fill_next - FW'(1);
          pne_next           = 1'b1;
        end else if (run && (pne_next || !skip_empty)) begin
          emit            = 1'b1;
          res.piece_end   = 1'b1;
          res.string_done = 1'b1;
          end_str         = 1'b1;
          finish          = 1'b1;
        end else if (!any) begin
          emit            = 1'b1;
          res.string_done = 1'b1;
          end_str         = 1'b1;
          finish          = 1'b1;
        end else begin
          end_str = 1'b1;
          finish  = 1'b1;
        end
      end
    end

    // string end returns the counters to zero
    if (end_str) begin
      fill_next   = '0;
      pne_next    = 1'b0;
      pieces_next = '0;
      lim_next    = 1'b0;
    end
  end

  // input handshake
  assign in_ch.ready = !cur_v || (fire && finish);
  assign load        = in_ch.valid && in_ch.ready;

  // item register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_v <= 1'b0;
      cp    <= 1'b0;
      ap    <= 1'b0;
      any   <= 1'b0;
    end else if (load) begin
      cur_v <= 1'b1;
      cp    <= in_ch.char_present && (len_eff != '0);
      ap    <= in_ch.char_present && (len_eff != '0);
      any   <= 1'b0;
    end else if (fire) begin
      cur_v <= !finish;
      cp    <= cp_next;
      ap    <= 1'b0;
      any   <= any || emit;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_char <= in_ch.in_char;
      cur_last <= in_ch.string_last;
    end
  end

  // string state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      pne    <= 1'b0;
      pieces <= '0;
      lim_r  <= 1'b0;
    end else if (fire) begin
      fill   <= fill_next;
      pne    <= pne_next;
      pieces <= pieces_next;
      lim_r  <= lim_next;
    end
  end

  // look-ahead window
  ssplit_window #(
    .DELIM_MAX (DELIM_MAX),
    .CHAR_BITS (CHAR_BITS)
  ) u_window (
    .clk         (clk),
    .op          (op),
    .fill        (fill),
    .len         (len_eff),
    .new_char    (cur_char),
    .delim_chars (delim_chars),
    .head        (head),
    .match       (match)
  );

  // result buffer
  ssplit_obuf u_obuf (
    .clk   (clk),
    .rst   (rst),
    .push  (fire && emit),
    .din   (res),
    .space (space),
    .res   (out_ch)
  );

`ifndef SYNTHESIS
  // the window fill always stays below the window depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill) < DELIM_MAX)
    else $error("window fill reached the window depth");

  // a finished last beat leaves a clean string state
  a_string_clear: assert property (@(posedge clk) disable iff (rst)
    (fire && finish && cur_last) |=> (pieces == '0 && !lim_r && !pne && fill == '0))
    else $error("string state not cleared at string end");

  // a string end with no earlier result produces a result beat
  a_done_beat: assert property (@(posedge clk) disable iff (rst)
    (fire && end_str && !any) |-> (emit && res.string_done))
    else $error("string ended without a result");
`endif

endmodule

// ----- test/tb_delimiter_string_splitter.sv -----
// testbench for delimiter_string_splitter: directed and random strings, checked beat by beat
// depends on ssplit_pkg, ssplit_if and the delimiter_string_splitter top level
`timescale 1ns / 1ps

// predicts the result beats of the splitter and checks the ones that leave it
class split_scoreboard;
  logic [63:0] delim_chars;
  logic [3:0]  delim_len;
  bit          skip_empty;
  logic [15:0] piece_limit;

  logic [7:0]  window [8];
  int unsigned fill;
  bit          piece_open;
  int unsigned pieces;
  bit          at_limit;

  ssplit_pkg::res_t pending_beats [$];
  int unsigned      step_beats;
  int unsigned      errors;

  function new();
    int i;
    delim_chars = '0;
    delim_len   = ssplit_pkg::DLEN_RESET;
    skip_empty  = 1'b1;
    piece_limit = ssplit_pkg::LIMIT_UNLIMITED;
    for (i = 0; i < 8; i++) window[i] = '0;
    fill       = 0;
    piece_open = 0;
    pieces     = 0;
    at_limit   = 0;
    errors     = 0;
  endfunction

  function int unsigned pending();
    return pending_beats.size();
  endfunction

  function void set_reg(logic [1:0] idx, logic [63:0] val);
    case (idx)
      ssplit_pkg::REG_DELIM_CHARS: delim_chars = val;
      ssplit_pkg::REG_DELIM_LEN:   delim_len   = val[3:0];
      ssplit_pkg::REG_SKIP_EMPTY:  skip_empty  = val[0];
      ssplit_pkg::REG_PIECE_LIMIT: piece_limit = val[15:0];
      default: ;
    endcase
  endfunction

  function void push_beat(logic [7:0] ch, bit chv, bit pend);
    ssplit_pkg::res_t r;
    r.out_char       = chv ? ch : 8'h00;
    r.out_char_valid = chv;
    r.piece_end      = pend;
    r.string_done    = 1'b0;
    pending_beats.push_back(r);
    step_beats++;
  endfunction

  // oldest window character leaves as a piece character
  function void pop_char();
    int unsigned i;
    push_beat(window[0], 1'b1, 1'b0);
    for (i = 1; i < fill && i < 8; i++) window[i-1] = window[i];
    if (fill > 0) fill--;
    piece_open = 1'b1;
  endfunction

  function void close_piece();
    if (piece_open || !skip_empty) begin
      push_beat(8'h00, 1'b0, 1'b1);
      if (pieces < 16'hFFFF) pieces++;
    end
    piece_open = 1'b0;
  endfunction

  function bit stopped();
    if (at_limit) return 1'b1;
    if (piece_limit != ssplit_pkg::LIMIT_UNLIMITED && pieces >= piece_limit) begin
      at_limit = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // one accepted input beat
  function void note_char_beat(logic [7:0] ch, bit present, bit last);
    int unsigned len;
    int unsigned i;
    bit hit;
    ssplit_pkg::res_t tail;
    len = (delim_len > 8) ? 8 : delim_len;
    step_beats = 0;
    if (len == 0) begin
      fill = 0;
    end else if (present && !stopped()) begin
      if (fill < 8) begin
        window[fill] = ch;
        fill++;
      end
      while (fill > len) pop_char();
      if (fill == len) begin
        hit = 1'b1;
        for (i = 0; i < len; i++)
          if (window[i] != delim_chars[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          fill = 0;
          close_piece();
        end else begin
          pop_char();
        end
      end
    end
    // string end flushes the window and closes the last piece if len != 0 and not stopped
    if (last) begin
      if (len != 0 && !stopped()) begin
        while (fill > 0) pop_char();
        close_piece();
      end
      if (step_beats == 0) push_beat(8'h00, 1'b0, 1'b0);
      tail = pending_beats.pop_back();
      tail.string_done = 1'b1;
      pending_beats.push_back(tail);
      fill       = 0;
      piece_open = 0;
      pieces     = 0;
      at_limit   = 0;
    end
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: mismatch in %s: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result_beat(ssplit_pkg::res_t got);
    ssplit_pkg::res_t want;
    if (pending_beats.size() == 0) begin
      $display("%0t: unexpected result beat: expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = pending_beats.pop_front();
    compare_field("out_char", want.out_char, got.out_char);
    compare_field("out_char_valid", 8'(want.out_char_valid), 8'(got.out_char_valid));
    compare_field("piece_end", 8'(want.piece_end), 8'(got.piece_end));
    compare_field("string_done", 8'(want.string_done), 8'(got.string_done));
  endfunction
endclass

module tb_delimiter_string_splitter;

  logic                                  clk;
  logic                                  rst;
  logic                                  cfg_we;
  logic [ssplit_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [ssplit_pkg::CFG_DATA_BITS-1:0]  cfg_data;

  ssplit_in_if #(.CHAR_BITS(8)) in_ch ();
  ssplit_out_if                 out_ch ();

  split_scoreboard sb;

  // idling percentages of the current phase
  int unsigned src_idle;
  int unsigned snk_stall;

  // delimiter and alphabet of the current random block
  logic [63:0] blk_chars;
  int unsigned blk_len;
  logic [7:0]  blk_alpha [4];

  delimiter_string_splitter #(.DELIM_MAX(8), .CHAR_BITS(8)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5000000;
    $display("delimiter_string_splitter regression: fail");
    $finish;
  end

  // receiver: check each result beat, then pick the next ready
  initial begin
    ssplit_pkg::res_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.out_char       = out_ch.out_char;
        got.out_char_valid = out_ch.out_char_valid;
        got.piece_end      = out_ch.piece_end;
        got.string_done    = out_ch.string_done;
        sb.check_result_beat(got);
      end
      out_ch.ready <= !rst && ($urandom_range(0, 99) >= snk_stall);
    end
  end

  // one input beat, with random idle cycles before it
  task automatic send_item(input logic [7:0] ch, input bit present, input bit last);
    while (src_idle != 0 && $urandom_range(0, 99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.in_char      <= ch;
    in_ch.char_present <= present;
    in_ch.string_last  <= last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sb.note_char_beat(ch, present, last);
  endtask

  // hold off the sender until every expected beat is out, then let the block settle
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // write all four registers, upper data bits carry noise
  task automatic set_config(input logic [63:0] chars, input logic [3:0] len, input bit skip,
                            input logic [15:0] limit);
    logic [ssplit_pkg::CFG_INDEX_BITS-1:0] idx [4];
    logic [63:0]                           val [4];
    int                                    i;
    idx[0] = ssplit_pkg::REG_DELIM_CHARS;
    idx[1] = ssplit_pkg::REG_DELIM_LEN;
    idx[2] = ssplit_pkg::REG_SKIP_EMPTY;
    idx[3] = ssplit_pkg::REG_PIECE_LIMIT;
    val[0] = chars;
    val[1] = {$urandom, $urandom};
    val[1][3:0] = len;
    val[2] = {$urandom, $urandom};
    val[2][0] = skip;
    val[3] = {$urandom, $urandom};
    val[3][15:0] = limit;
    for (i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // one random string built from delimiters, partial delimiters and plain characters
  task automatic send_string(output int count);
    logic [7:0] text [$];
    logic [7:0] ch;
    int         segs;
    int         kind;
    int         cut;
    int         j;
    int         k;
    bit         tail_marker;
    count = 0;
    segs = $urandom_range(0, 5);
    for (j = 0; j < segs && text.size() < 12; j++) begin
      kind = $urandom_range(0, 3);
      if (blk_len != 0 && kind <= 1) begin
        cut = (kind == 0) ? blk_len : $urandom_range(1, blk_len);
        for (k = 0; k < cut; k++) text.push_back(blk_chars[8*k +: 8]);
      end else begin
        cut = $urandom_range(1, 3);
        for (k = 0; k < cut; k++) begin
          if ($urandom_range(0, 5) == 0) ch = 8'($urandom_range(0, 255));
          else ch = blk_alpha[$urandom_range(0, 3)];
          text.push_back(ch);
        end
      end
    end
    tail_marker = ($urandom_range(0, 4) == 0);
    if (text.size() == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      count = 1;
    end else begin
      for (j = 0; j < text.size(); j++) begin
        // beat with neither character nor end, ignored by the block
        if ($urandom_range(0, 19) == 0) begin
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
          count++;
        end
        send_item(text[j], 1'b1, (j == text.size() - 1) && !tail_marker);
        count++;
      end
      if (tail_marker) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        count++;
      end
    end
  endtask

  // stimulus
  initial begin
    int          blk;
    int          sent;
    int          n;
    int          i;
    logic [3:0]  len;
    logic [15:0] limit;

    sb = new();
    src_idle  = 0;
    snk_stall = 0;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.in_char      <= '0;
    in_ch.char_present <= 1'b0;
    in_ch.string_last  <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: single zero delimiter, empty pieces dropped
    send_item("a", 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b1);
    // string with no character at all, then an ignored beat
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h5A, 1'b0, 1'b0);

    // two-character delimiter, empty pieces kept, end marked by an empty beat
    wait_quiet();
    set_config(64'h0000_0000_0000_6261, 4'd2, 1'b0, ssplit_pkg::LIMIT_UNLIMITED);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item("a", 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b0);
    send_item("a", 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    // delimiter shortened while characters sit in the window
    wait_quiet();
    set_config(64'h6867_6665_6463_6261, 4'd8, 1'b0, ssplit_pkg::LIMIT_UNLIMITED);
    send_item("a", 1'b1, 1'b0);
    send_item("x", 1'b1, 1'b0);
    send_item("a", 1'b1, 1'b0);
    wait_quiet();
    set_config(64'h6867_6665_6463_6261, 4'd2, 1'b0, ssplit_pkg::LIMIT_UNLIMITED);
    send_item("b", 1'b1, 1'b1);

    // zero delimiter length drops everything
    wait_quiet();
    set_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, ssplit_pkg::LIMIT_UNLIMITED);
    send_item("q", 1'b1, 1'b0);
    send_item("r", 1'b1, 1'b1);

    // oversized length with a zero piece limit
    wait_quiet();
    set_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 16'd0);
    send_item("k", 1'b1, 1'b1);

    // piece limit of one cuts the string short
    wait_quiet();
    set_config(64'h0000_0000_0000_002C, 4'd1, 1'b1, 16'd1);
    send_item("a", 1'b1, 1'b0);
    send_item(",", 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b1);

    // random blocks, each with its own settings and idling phase
    for (blk = 0; blk < 16; blk++) begin
      wait_quiet();
      for (i = 0; i < 4; i++) blk_alpha[i] = 8'($urandom_range(0, 255));
      blk_chars = {$urandom, $urandom};
      if (blk == 5) begin
        blk_chars    = 64'hFFFF_FFFF_FFFF_FFFF;
        blk_alpha[0] = 8'hFF;
      end else if (blk == 9) begin
        blk_chars    = 64'h0;
        blk_alpha[0] = 8'h00;
      end else begin
        for (i = 0; i < 8; i++)
          if ($urandom_range(0, 3) != 0) blk_chars[8*i +: 8] = blk_alpha[$urandom_range(0, 3)];
      end
      case (blk)
        0:       len = 4'd1;
        1:       len = 4'd8;
        2:       len = 4'd15;
        3:       len = 4'd0;
        default: len = 4'($urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(1, 15));
      endcase
      case ($urandom_range(0, 5))
        3:       limit = 16'($urandom_range(0, 3));
        4:       limit = 16'($urandom_range(0, 65535));
        5:       limit = 16'hFFFE;
        default: limit = ssplit_pkg::LIMIT_UNLIMITED;
      endcase
      set_config(blk_chars, len, 1'($urandom_range(0, 1)), limit);
      blk_len = (len > 8) ? 8 : len;
      case (blk % 4)
        0: begin src_idle = 0;  snk_stall = 0;  end
        1: begin src_idle = 65; snk_stall = 0;  end
        2: begin src_idle = 0;  snk_stall = 65; end
        default: begin src_idle = 28; snk_stall = 28; end
      endcase
      sent = 0;
      while (sent < 25) begin
        send_string(n);
        sent += n;
      end
    end

    // drain and settle
    wait_quiet();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("delimiter_string_splitter regression: pass");
    end else begin
      $display("delimiter_string_splitter regression: fail");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
hdl/ssplit_pkg.sv
hdl/ssplit_if.sv
hdl/ssplit_cell.sv
hdl/ssplit_window.sv
hdl/ssplit_obuf.sv
hdl/delimiter_string_splitter.sv
test/tb_delimiter_string_splitter.sv
